@@ rtl/c65x_pkg.sv @@
// Shared definitions for the 6502 execute unit: selector codes, flag bits,
// and the register and result records passed between the datapath modules.
// No dependencies.
package c65x_pkg;

   localparam int CMD_W = 5;

   localparam logic [CMD_W-1:0] CMD_ADC = 5'd0;
   localparam logic [CMD_W-1:0] CMD_AND = 5'd1;
   localparam logic [CMD_W-1:0] CMD_ASL = 5'd2;
   localparam logic [CMD_W-1:0] CMD_BCC = 5'd3;
   localparam logic [CMD_W-1:0] CMD_BCS = 5'd4;
   localparam logic [CMD_W-1:0] CMD_BEQ = 5'd5;
   localparam logic [CMD_W-1:0] CMD_BNE = 5'd6;
   localparam logic [CMD_W-1:0] CMD_BIT = 5'd7;
   localparam logic [CMD_W-1:0] CMD_BMI = 5'd8;
   localparam logic [CMD_W-1:0] CMD_BPL = 5'd9;
   localparam logic [CMD_W-1:0] CMD_BRK = 5'd10;
   localparam logic [CMD_W-1:0] CMD_BVC = 5'd11;
   localparam logic [CMD_W-1:0] CMD_BVS = 5'd12;
   localparam logic [CMD_W-1:0] CMD_CLC = 5'd13;
   localparam logic [CMD_W-1:0] CMD_CLD = 5'd14;
   localparam logic [CMD_W-1:0] CMD_CLI = 5'd15;
   localparam logic [CMD_W-1:0] CMD_CLV = 5'd16;
   localparam logic [CMD_W-1:0] CMD_CMP = 5'd17;
   localparam logic [CMD_W-1:0] CMD_CPX = 5'd18;
   localparam logic [CMD_W-1:0] CMD_CPY = 5'd19;
   localparam logic [CMD_W-1:0] CMD_DEC = 5'd20;
   localparam logic [CMD_W-1:0] CMD_DEX = 5'd21;
   localparam logic [CMD_W-1:0] CMD_DEY = 5'd22;
   localparam logic [CMD_W-1:0] CMD_EOR = 5'd23;
   localparam logic [CMD_W-1:0] CMD_INC = 5'd24;
   localparam logic [CMD_W-1:0] CMD_INX = 5'd25;
   localparam logic [CMD_W-1:0] CMD_INY = 5'd26;

   // status bit positions, NV-BDIZC
   localparam int FLAG_C = 0;
   localparam int FLAG_Z = 1;
   localparam int FLAG_I = 2;
   localparam int FLAG_D = 3;
   localparam int FLAG_B = 4;
   localparam int FLAG_V = 6;
   localparam int FLAG_N = 7;

   localparam logic [7:0]  STATUS_RESET = 8'h24;
   localparam logic [7:0]  SP_RESET     = 8'hFD;
   localparam logic [15:0] STACK_PAGE   = 16'h0100;

   // beats beyond the first for an instruction
   localparam logic [1:0] BRK_EXTRA_BEATS = 2'd2;
   localparam logic [1:0] ONE_BEAT        = 2'd0;

   typedef struct packed {
      logic [7:0] acc;
      logic [7:0] x;
      logic [7:0] y;
      logic [7:0] status;
      logic [7:0] sp;
   } regs_type;

   typedef struct packed {
      regs_type        regs;
      logic [15:0]     pc;
      logic            mem_write;
      logic [1:0]      extra_beats;
      logic [2:0][15:0] wr_addr;
      logic [2:0][7:0]  wr_data;
   } exec_type;

endpackage

@@ rtl/c65x_alu.sv @@
// Combinational execute datapath: decodes one instruction and forms the next
// register file, program counter and up to three memory writes.
// Depends on c65x_pkg.
module c65x_alu (
   input  logic [4:0]         cmd,
   input  logic [7:0]         operand,
   input  logic [15:0]        address,
   input  logic               accumulator_mode,
   input  logic [15:0]        next_pc,
   input  logic [15:0]        break_vector,
   input  c65x_pkg::regs_type cur,
   output c65x_pkg::exec_type res
);

   logic [8:0]  sum;
   logic [7:0]  adc_r;
   logic [7:0]  shift_src;
   logic [7:0]  shift_r;
   logic [7:0]  cmp_reg;
   logic [7:0]  cmp_diff;
   logic [15:0] target;
   logic [15:0] ret_addr;
   logic [7:0]  s;
   logic        taken;
   logic        is_branch;
   logic        nz_en;
   logic [7:0]  nz_val;

   always_comb begin
      s         = cur.status;
      sum       = {1'b0, cur.acc} + {1'b0, operand} + {8'h00, s[c65x_pkg::FLAG_C]};
      adc_r     = sum[7:0];
      shift_src = accumulator_mode ? cur.acc : operand;
      shift_r   = {shift_src[6:0], 1'b0};
      target    = next_pc + {{8{operand[7]}}, operand};
      ret_addr  = next_pc + 16'd1;

      case (cmd)
         c65x_pkg::CMD_CPX: cmp_reg = cur.x;
         c65x_pkg::CMD_CPY: cmp_reg = cur.y;
         default:           cmp_reg = cur.acc;
      endcase
      cmp_diff = cmp_reg - operand;

      res             = '0;
      res.regs        = cur;
      res.pc          = next_pc;
      res.extra_beats = c65x_pkg::ONE_BEAT;
      taken           = 1'b0;
      is_branch       = 1'b0;
      nz_en           = 1'b0;
      nz_val          = 8'h00;

      unique case (cmd)
         c65x_pkg::CMD_ADC: begin
            res.regs.acc                     = adc_r;
            res.regs.status[c65x_pkg::FLAG_C] = sum[8];
            res.regs.status[c65x_pkg::FLAG_V] = (cur.acc[7] ^ adc_r[7]) & (operand[7] ^ adc_r[7]);
            nz_en  = 1'b1;
            nz_val = adc_r;
         end
         c65x_pkg::CMD_AND: begin
            res.regs.acc = cur.acc & operand;
            nz_en  = 1'b1;
            nz_val = cur.acc & operand;
         end
         c65x_pkg::CMD_EOR: begin
            res.regs.acc = cur.acc ^ operand;
            nz_en  = 1'b1;
            nz_val = cur.acc ^ operand;
         end
         c65x_pkg::CMD_ASL: begin
            res.regs.status[c65x_pkg::FLAG_C] = shift_src[7];
            nz_en  = 1'b1;
            nz_val = shift_r;
            if (accumulator_mode) begin
               res.regs.acc = shift_r;
            end else begin
               res.mem_write  = 1'b1;
               res.wr_addr[0] = address;
               res.wr_data[0] = shift_r;
            end
         end
         c65x_pkg::CMD_BCC: begin
            is_branch = 1'b1;
            taken     = !s[c65x_pkg::FLAG_C];
         end
         c65x_pkg::CMD_BCS: begin
            is_branch = 1'b1;
            taken     = s[c65x_pkg::FLAG_C];
         end
         c65x_pkg::CMD_BEQ: begin
            is_branch = 1'b1;
            taken     = s[c65x_pkg::FLAG_Z];
         end
         c65x_pkg::CMD_BNE: begin
            is_branch = 1'b1;
            taken     = !s[c65x_pkg::FLAG_Z];
         end
         c65x_pkg::CMD_BMI: begin
            is_branch = 1'b1;
            taken     = s[c65x_pkg::FLAG_N];
         end
         c65x_pkg::CMD_BPL: begin
            is_branch = 1'b1;
            taken     = !s[c65x_pkg::FLAG_N];
         end
         c65x_pkg::CMD_BVC: begin
            is_branch = 1'b1;
            taken     = !s[c65x_pkg::FLAG_V];
         end
         c65x_pkg::CMD_BVS: begin
            is_branch = 1'b1;
            taken     = s[c65x_pkg::FLAG_V];
         end
         c65x_pkg::CMD_BIT: begin
            res.regs.status[c65x_pkg::FLAG_N] = operand[7];
            res.regs.status[c65x_pkg::FLAG_V] = operand[6];
            res.regs.status[c65x_pkg::FLAG_Z] = ((operand & cur.acc) == 8'h00);
         end
         c65x_pkg::CMD_BRK: begin
            // three pushes: return high, return low, status with B set
            res.regs.sp                       = cur.sp - 8'd3;
            res.regs.status[c65x_pkg::FLAG_I] = 1'b1;
            res.pc          = break_vector;
            res.mem_write   = 1'b1;
            res.extra_beats = c65x_pkg::BRK_EXTRA_BEATS;
            res.wr_addr[0]  = c65x_pkg::STACK_PAGE | {8'h00, cur.sp};
            res.wr_addr[1]  = c65x_pkg::STACK_PAGE | {8'h00, 8'(cur.sp - 8'd1)};
            res.wr_addr[2]  = c65x_pkg::STACK_PAGE | {8'h00, 8'(cur.sp - 8'd2)};
            res.wr_data[0]  = ret_addr[15:8];
            res.wr_data[1]  = ret_addr[7:0];
            res.wr_data[2]  = s | 8'h10;
         end
         c65x_pkg::CMD_CLC: res.regs.status[c65x_pkg::FLAG_C] = 1'b0;
         c65x_pkg::CMD_CLD: res.regs.status[c65x_pkg::FLAG_D] = 1'b0;
         c65x_pkg::CMD_CLI: res.regs.status[c65x_pkg::FLAG_I] = 1'b0;
         c65x_pkg::CMD_CLV: res.regs.status[c65x_pkg::FLAG_V] = 1'b0;
         c65x_pkg::CMD_CMP, c65x_pkg::CMD_CPX, c65x_pkg::CMD_CPY: begin
            res.regs.status[c65x_pkg::FLAG_C] = (cmp_reg >= operand);
            nz_en  = 1'b1;
            nz_val = cmp_diff;
         end
         c65x_pkg::CMD_DEC: begin
            res.mem_write  = 1'b1;
            res.wr_addr[0] = address;
            res.wr_data[0] = operand - 8'd1;
            nz_en  = 1'b1;
            nz_val = operand - 8'd1;
         end
         c65x_pkg::CMD_INC: begin
            res.mem_write  = 1'b1;
            res.wr_addr[0] = address;
            res.wr_data[0] = operand + 8'd1;
            nz_en  = 1'b1;
            nz_val = operand + 8'd1;
         end
         c65x_pkg::CMD_DEX: begin
            res.regs.x = cur.x - 8'd1;
            nz_en  = 1'b1;
            nz_val = cur.x - 8'd1;
         end
         c65x_pkg::CMD_DEY: begin
            res.regs.y = cur.y - 8'd1;
            nz_en  = 1'b1;
            nz_val = cur.y - 8'd1;
         end
         c65x_pkg::CMD_INX: begin
            res.regs.x = cur.x + 8'd1;
            nz_en  = 1'b1;
            nz_val = cur.x + 8'd1;
         end
         c65x_pkg::CMD_INY: begin
            res.regs.y = cur.y + 8'd1;
            nz_en  = 1'b1;
            nz_val = cur.y + 8'd1;
         end
         default: begin
         end
      endcase

      if (is_branch && taken) begin
         res.pc = target;
      end
      if (nz_en) begin
         res.regs.status[c65x_pkg::FLAG_N] = nz_val[7];
         res.regs.status[c65x_pkg::FLAG_Z] = (nz_val == 8'h00);
      end
   end

endmodule

@@ rtl/cpu6502_alu_branch_execute.sv @@
// 6502 execute unit: register file, break vector and result stage around c65x_alu.
// An accepted item's first result item is registered and shown in the cycle after.
// One item per cycle when the result stage is free; BRK holds the input for its three
// result items, which drain one per cycle from the shift slots while rsp_tready is high.
// Reset: synchronous; A, X, Y = 0, status = 0x24, SP = 0xFD, break vector = 0,
// result stage empty. Depends on c65x_pkg and c65x_alu.
module cpu6502_alu_branch_execute (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // cmd[4:0], operand[12:5], address[28:13], accumulator_mode[29], next_pc[45:30]
   input  logic [47:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // write_addr[15:0], write_data[23:16], acc_out[31:24], x_out[39:32],
   // y_out[47:40], status_out[55:48], pc_out[71:56], sp_out[79:72]
   output logic [79:0] rsp_tdata,
   // mem_write[0]
   output logic        rsp_tuser,
   output logic        rsp_tlast,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [15:0] csr_data
);

   c65x_pkg::regs_type regs_ff;
   c65x_pkg::exec_type res;

   logic [15:0]      brk_vec_ff;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [1:0]       beats_ff, beats_in;
   logic             wr_ff, wr_in;
   logic [2:0][15:0] wa_ff, wa_in;
   logic [2:0][7:0]  wd_ff, wd_in;
   c65x_pkg::regs_type out_regs_ff, out_regs_in;
   logic [15:0]      pc_ff, pc_in;
   logic             req_accept;
   logic             rsp_accept;
   logic             final_beat;

   c65x_alu u_alu (
      .cmd              (req_tdata[4:0]),
      .operand          (req_tdata[12:5]),
      .address          (req_tdata[28:13]),
      .accumulator_mode (req_tdata[29]),
      .next_pc          (req_tdata[45:30]),
      .break_vector     (brk_vec_ff),
      .cur              (regs_ff),
      .res              (res)
   );

   assign final_beat = (beats_ff == c65x_pkg::ONE_BEAT);
   assign rsp_accept = rsp_valid_ff && rsp_tready;
   // take a new item whenever the result stage is empty or is handing over its last beat
   assign req_tready = !rsp_valid_ff || (rsp_tready && final_beat);
   assign req_accept = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      beats_in     = beats_ff;
      wr_in        = wr_ff;
      wa_in        = wa_ff;
      wd_in        = wd_ff;
      out_regs_in  = out_regs_ff;
      pc_in        = pc_ff;
      if (req_accept) begin
         rsp_valid_in = 1'b1;
         beats_in     = res.extra_beats;
         wr_in        = res.mem_write;
         wa_in        = res.wr_addr;
         wd_in        = res.wr_data;
         out_regs_in  = res.regs;
         pc_in        = res.pc;
      end else if (rsp_accept) begin
         if (final_beat) begin
            rsp_valid_in = 1'b0;
         end else begin
            // advance to the next push
            beats_in = beats_ff - 2'd1;
            wa_in    = {16'h0000, wa_ff[2:1]};
            wd_in    = {8'h00, wd_ff[2:1]};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         regs_ff.acc    <= 8'h00;
         regs_ff.x      <= 8'h00;
         regs_ff.y      <= 8'h00;
         regs_ff.status <= c65x_pkg::STATUS_RESET;
         regs_ff.sp     <= c65x_pkg::SP_RESET;
         brk_vec_ff     <= 16'h0000;
         rsp_valid_ff   <= 1'b0;
         beats_ff       <= c65x_pkg::ONE_BEAT;
      end else begin
         if (req_accept) begin
            regs_ff <= res.regs;
         end
         if (csr_valid) begin
            brk_vec_ff <= csr_data;
         end
         rsp_valid_ff <= rsp_valid_in;
         beats_ff     <= beats_in;
      end
   end

   always_ff @(posedge clock) begin
      wr_ff       <= wr_in;
      wa_ff       <= wa_in;
      wd_ff       <= wd_in;
      out_regs_ff <= out_regs_in;
      pc_ff       <= pc_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = wr_ff;
   assign rsp_tlast  = final_beat;
   assign rsp_tdata  = {out_regs_ff.sp, pc_ff, out_regs_ff.status, out_regs_ff.y,
                        out_regs_ff.x, out_regs_ff.acc, wd_ff[0], wa_ff[0]};

endmodule

@@ rtl/c65x_checker.sv @@
// Port-level checks for the 6502 execute unit, attached by bind.
// Sees only the top level's ports; no package dependency.
module c65x_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [79:0] rsp_tdata,
   input logic        rsp_tuser,
   input logic        rsp_tlast
);

   // result must not be withdrawn while stalled
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("result item dropped while stalled");

   // pushes of a BRK follow back to back, each a write
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && !rsp_tlast |=> rsp_tvalid && rsp_tuser)
      else $error("multi-item result broken");

   // register and pc fields hold across the items of one instruction
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && !rsp_tlast |=> $stable(rsp_tdata[79:24]))
      else $error("register fields changed within one instruction");

   // no new item while an instruction still has items to deliver
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tlast |-> !req_tready)
      else $error("item accepted mid-instruction");

   assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid after reset");

endmodule

bind cpu6502_alu_branch_execute c65x_checker u_c65x_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);

@@ test/tb_cpu6502_alu_branch_execute.sv @@
// Self-checking testbench for the 6502 execute unit: queue-fed stream driver, result
// monitor and an in-bench shadow of A, X, Y, status, SP and the break vector.
// Depends on c65x_pkg and the cpu6502_alu_branch_execute top level.
`timescale 1ns / 1ps

module tb_cpu6502_alu_branch_execute;
   import c65x_pkg::*;

   localparam int CYCLE_LIMIT = 400000;
   localparam int REPORT_MAX  = 30;

   // selector codes beyond the last instruction do nothing
   localparam logic [CMD_W-1:0] CMD_UNUSED_FIRST = CMD_INY + 5'd1;
   localparam logic [CMD_W-1:0] CMD_UNUSED_LAST  = 5'd31;

   typedef struct packed {
      logic [15:0] next_pc;
      logic        amode;
      logic [15:0] address;
      logic [7:0]  operand;
      logic [4:0]  cmd;
   } instr_type;

   typedef struct packed {
      logic        mem_write;
      logic [15:0] waddr;
      logic [7:0]  wdata;
      logic [7:0]  acc;
      logic [7:0]  x;
      logic [7:0]  y;
      logic [7:0]  status;
      logic [15:0] pc;
      logic [7:0]  sp;
      logic        last;
   } beat_type;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [47:0] req_tdata  = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [79:0] rsp_tdata;
   logic        rsp_tuser;
   logic        rsp_tlast;
   logic        csr_valid  = 1'b0;
   logic        csr_ready;
   logic [15:0] csr_data   = '0;

   cpu6502_alu_branch_execute DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   // architectural shadow state
   logic [7:0]  arch_acc    = 8'h00;
   logic [7:0]  arch_x      = 8'h00;
   logic [7:0]  arch_y      = 8'h00;
   logic [7:0]  arch_status = STATUS_RESET;
   logic [7:0]  arch_sp     = SP_RESET;
   logic [15:0] arch_vector = 16'h0000;

   instr_type fetch_q[$];
   beat_type  retired_beats[$];
   instr_type req_item;

   int mismatch_count = 0;
   int instr_count    = 0;
   int brk_count      = 0;
   int result_count   = 0;
   int vector_writes  = 0;
   int cycle_count    = 0;
   int send_gap       = 0;
   int send_calm      = 0;
   int recv_hold      = 0;
   int recv_calm      = 0;

   task automatic log_mismatch(input string what, input logic [15:0] got,
                               input logic [15:0] want);
      mismatch_count++;
      if (mismatch_count <= REPORT_MAX)
         $display("[%0t] mismatch at result %0d, %s: got %h want %h",
                  $realtime, result_count, what, got, want);
   endtask

   task automatic check_field(input string what, input logic [15:0] got,
                              input logic [15:0] want);
      if (got !== want) log_mismatch(what, got, want);
   endtask

   // mostly zero, some short, a few long; now and then a calm stretch with none
   task automatic pick_idle(inout int calm, output int len);
      int r;
      len = 0;
      if (calm > 0) begin
         calm--;
      end else begin
         r = $urandom_range(0, 99);
         if (r < 3) calm = $urandom_range(20, 80);
         else if (r < 60) len = 0;
         else if (r < 88) len = $urandom_range(1, 3);
         else if (r < 96) len = $urandom_range(4, 9);
         else len = $urandom_range(10, 40);
      end
   endtask

   function automatic beat_type make_beat(logic wr, logic [15:0] wa, logic [7:0] wd,
                                          logic [15:0] pc, logic last);
      beat_type b;
      b.mem_write = wr;
      b.waddr     = wr ? wa : 16'h0000;
      b.wdata     = wr ? wd : 8'h00;
      b.acc       = arch_acc;
      b.x         = arch_x;
      b.y         = arch_y;
      b.status    = arch_status;
      b.pc        = pc;
      b.sp        = arch_sp;
      b.last      = last;
      return b;
   endfunction

   function automatic logic [15:0] branch_to(logic taken, logic [7:0] off,
                                             logic [15:0] pc);
      return taken ? pc + {{8{off[7]}}, off} : pc;
   endfunction

   task automatic set_nz(input logic [7:0] v);
      arch_status[FLAG_Z] = (v == 8'h00);
      arch_status[FLAG_N] = v[7];
   endtask

   task automatic compare_reg(input logic [7:0] r, input logic [7:0] m);
      logic [7:0] diff;
      diff = r - m;
      arch_status[FLAG_C] = (r >= m);
      set_nz(diff);
   endtask

   // advance the shadow state by one instruction and queue the items it retires
   task automatic execute_6502(input instr_type ins);
      logic [7:0]  s, op, r, src, wd, sp0, sp1, sp2, pushed;
      logic [8:0]  sum;
      logic [15:0] pc, ret;
      logic        wr;
      s   = arch_status;
      op  = ins.operand;
      pc  = ins.next_pc;
      wr  = 1'b0;
      wd  = 8'h00;
      sp0 = arch_sp;
      case (ins.cmd)
         CMD_ADC: begin
            sum = {1'b0, arch_acc} + {1'b0, op} + {8'h00, s[FLAG_C]};
            r = sum[7:0];
            arch_status[FLAG_C] = sum[8];
            arch_status[FLAG_V] = (arch_acc[7] ^ r[7]) & (op[7] ^ r[7]);
            arch_acc = r;
            set_nz(r);
         end
         CMD_AND: begin
            arch_acc = arch_acc & op;
            set_nz(arch_acc);
         end
         CMD_ASL: begin
            src = ins.amode ? arch_acc : op;
            r = {src[6:0], 1'b0};
            arch_status[FLAG_C] = src[7];
            set_nz(r);
            if (ins.amode) begin
               arch_acc = r;
            end else begin
               wr = 1'b1;
               wd = r;
            end
         end
         CMD_BCC: pc = branch_to(!s[FLAG_C], op, ins.next_pc);
         CMD_BCS: pc = branch_to(s[FLAG_C], op, ins.next_pc);
         CMD_BEQ: pc = branch_to(s[FLAG_Z], op, ins.next_pc);
         CMD_BNE: pc = branch_to(!s[FLAG_Z], op, ins.next_pc);
         CMD_BIT: begin
            arch_status[FLAG_N] = op[7];
            arch_status[FLAG_V] = op[6];
            arch_status[FLAG_Z] = ((op & arch_acc) == 8'h00);
         end
         CMD_BMI: pc = branch_to(s[FLAG_N], op, ins.next_pc);
         CMD_BPL: pc = branch_to(!s[FLAG_N], op, ins.next_pc);
         CMD_BRK: begin
            arch_sp = sp0 - 8'd3;
            arch_status[FLAG_I] = 1'b1;
            pc = arch_vector;
         end
         CMD_BVC: pc = branch_to(!s[FLAG_V], op, ins.next_pc);
         CMD_BVS: pc = branch_to(s[FLAG_V], op, ins.next_pc);
         CMD_CLC: arch_status[FLAG_C] = 1'b0;
         CMD_CLD: arch_status[FLAG_D] = 1'b0;
         CMD_CLI: arch_status[FLAG_I] = 1'b0;
         CMD_CLV: arch_status[FLAG_V] = 1'b0;
         CMD_CMP: compare_reg(arch_acc, op);
         CMD_CPX: compare_reg(arch_x, op);
         CMD_CPY: compare_reg(arch_y, op);
         CMD_DEC: begin
            wd = op - 8'd1;
            wr = 1'b1;
            set_nz(wd);
         end
         CMD_DEX: begin
            arch_x = arch_x - 8'd1;
            set_nz(arch_x);
         end
         CMD_DEY: begin
            arch_y = arch_y - 8'd1;
            set_nz(arch_y);
         end
         CMD_EOR: begin
            arch_acc = arch_acc ^ op;
            set_nz(arch_acc);
         end
         CMD_INC: begin
            wd = op + 8'd1;
            wr = 1'b1;
            set_nz(wd);
         end
         CMD_INX: begin
            arch_x = arch_x + 8'd1;
            set_nz(arch_x);
         end
         CMD_INY: begin
            arch_y = arch_y + 8'd1;
            set_nz(arch_y);
         end
         default: ;
      endcase
      if (ins.cmd == CMD_BRK) begin
         // push return high byte, low byte, then status with B set; SP wraps in page
         ret    = ins.next_pc + 16'd1;
         sp1    = sp0 - 8'd1;
         sp2    = sp0 - 8'd2;
         pushed = s;
         pushed[FLAG_B] = 1'b1;
         retired_beats.push_back(make_beat(1'b1, STACK_PAGE | {8'h00, sp0}, ret[15:8],
                                           pc, 1'b0));
         retired_beats.push_back(make_beat(1'b1, STACK_PAGE | {8'h00, sp1}, ret[7:0],
                                           pc, 1'b0));
         retired_beats.push_back(make_beat(1'b1, STACK_PAGE | {8'h00, sp2}, pushed,
                                           pc, 1'b1));
         brk_count++;
      end else begin
         retired_beats.push_back(make_beat(wr, ins.address, wd, pc, 1'b1));
      end
      instr_count++;
   endtask

   function automatic instr_type mk_instr(logic [4:0] c, logic [7:0] op,
                                          logic [15:0] addr, logic am,
                                          logic [15:0] npc);
      instr_type it;
      it.cmd      = c;
      it.operand  = op;
      it.address  = addr;
      it.amode    = am;
      it.next_pc  = npc;
      return it;
   endfunction

   // brk_pct steers how hard the stack is worked
   function automatic instr_type rand_instr(int brk_pct);
      instr_type it;
      int r;
      r = $urandom_range(0, 99);
      if (r < brk_pct) it.cmd = CMD_BRK;
      else if (r < brk_pct + 6)
         it.cmd = 5'($urandom_range(CMD_UNUSED_FIRST, CMD_UNUSED_LAST));
      else it.cmd = 5'($urandom_range(CMD_ADC, CMD_INY));
      case ($urandom_range(0, 9))
         0: it.operand = 8'h00;
         1: it.operand = 8'hFF;
         2: it.operand = 8'h80;
         3: it.operand = 8'h7F;
         default: it.operand = 8'($urandom_range(0, 255));
      endcase
      it.address = 16'($urandom_range(0, 65535));
      it.amode   = 1'($urandom_range(0, 1));
      case ($urandom_range(0, 19))
         0: it.next_pc = 16'h0000;
         1: it.next_pc = 16'hFFFF;
         default: it.next_pc = 16'($urandom_range(0, 65535));
      endcase
      return it;
   endfunction

   // wait until every queued item has gone in and every result has come out
   task automatic wait_drained();
      do @(negedge clock);
      while (fetch_q.size() != 0 || req_tvalid || retired_beats.size() != 0);
      repeat (3) @(negedge clock);
   endtask

   task automatic write_break_vector(input logic [15:0] v);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_data  <= v;
      do @(negedge clock);
      while (!csr_ready);
      @(posedge clock);
      csr_valid   <= 1'b0;
      arch_vector  = v;
      vector_writes++;
   endtask

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         send_gap    = 0;
      end else begin
         if (req_tvalid && req_tready) execute_6502(req_item);
         if (!req_tvalid || req_tready) begin
            if (send_gap > 0) begin
               send_gap--;
               req_tvalid <= 1'b0;
            end else if (fetch_q.size() > 0) begin
               req_item = fetch_q.pop_front();
               req_tdata  <= {2'b00, req_item};
               req_tvalid <= 1'b1;
               pick_idle(send_calm, send_gap);
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // result monitor and backpressure
   always @(posedge clock) begin
      beat_type got, want;
      if (reset) begin
         rsp_tready <= 1'b0;
         recv_hold   = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            result_count++;
            got.mem_write = rsp_tuser;
            got.waddr     = rsp_tdata[15:0];
            got.wdata     = rsp_tdata[23:16];
            got.acc       = rsp_tdata[31:24];
            got.x         = rsp_tdata[39:32];
            got.y         = rsp_tdata[47:40];
            got.status    = rsp_tdata[55:48];
            got.pc        = rsp_tdata[71:56];
            got.sp        = rsp_tdata[79:72];
            got.last      = rsp_tlast;
            if (retired_beats.size() == 0) begin
               log_mismatch("unexpected result item", got.pc, 16'h0000);
            end else begin
               want = retired_beats.pop_front();
               check_field("mem_write", 16'(got.mem_write), 16'(want.mem_write));
               check_field("write_addr", got.waddr, want.waddr);
               check_field("write_data", 16'(got.wdata), 16'(want.wdata));
               check_field("acc_out", 16'(got.acc), 16'(want.acc));
               check_field("x_out", 16'(got.x), 16'(want.x));
               check_field("y_out", 16'(got.y), 16'(want.y));
               check_field("status_out", 16'(got.status), 16'(want.status));
               check_field("pc_out", got.pc, want.pc);
               check_field("sp_out", 16'(got.sp), 16'(want.sp));
               check_field("last", 16'(got.last), 16'(want.last));
            end
         end
         if (recv_hold > 0) begin
            recv_hold--;
            rsp_tready <= 1'b0;
         end else begin
            if ($urandom_range(0, 2) == 0) pick_idle(recv_calm, recv_hold);
            rsp_tready <= (recv_hold == 0);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding",
                  cycle_count, retired_beats.size());
         $display("*** FAILED ***");
         $finish;
      end
   end

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      write_break_vector(16'hFFFF);

      // directed: field extremes, every instruction, wraps and the unused selectors
      fetch_q.push_back(mk_instr(CMD_ADC, 8'hFF, 16'h0000, 1'b0, 16'h0000));
      fetch_q.push_back(mk_instr(CMD_ADC, 8'h01, 16'hFFFF, 1'b1, 16'hFFFF));
      fetch_q.push_back(mk_instr(CMD_ADC, 8'h7F, 16'h1234, 1'b0, 16'h8000));
      fetch_q.push_back(mk_instr(CMD_AND, 8'hFF, 16'h00FF, 1'b1, 16'h0200));
      fetch_q.push_back(mk_instr(CMD_ASL, 8'h00, 16'h4321, 1'b1, 16'h0201));
      fetch_q.push_back(mk_instr(CMD_ASL, 8'h81, 16'hFFFF, 1'b0, 16'h0202));
      fetch_q.push_back(mk_instr(CMD_BCC, 8'h80, 16'h0000, 1'b0, 16'h0000));
      fetch_q.push_back(mk_instr(CMD_BCS, 8'h7F, 16'h0000, 1'b1, 16'hFFFF));
      fetch_q.push_back(mk_instr(CMD_BEQ, 8'h80, 16'hAAAA, 1'b0, 16'h0040));
      fetch_q.push_back(mk_instr(CMD_BNE, 8'h01, 16'h5555, 1'b0, 16'hFFFE));
      fetch_q.push_back(mk_instr(CMD_BIT, 8'hC0, 16'h0010, 1'b0, 16'h0300));
      fetch_q.push_back(mk_instr(CMD_BMI, 8'hFE, 16'h0011, 1'b1, 16'h0001));
      fetch_q.push_back(mk_instr(CMD_BPL, 8'h02, 16'h0012, 1'b0, 16'hFFFF));
      fetch_q.push_back(mk_instr(CMD_BVC, 8'h80, 16'h0013, 1'b0, 16'h0010));
      fetch_q.push_back(mk_instr(CMD_BVS, 8'h7F, 16'h0014, 1'b1, 16'hFF90));
      fetch_q.push_back(mk_instr(CMD_BRK, 8'h00, 16'h0000, 1'b1, 16'hFFFF));
      fetch_q.push_back(mk_instr(CMD_CLC, 8'hFF, 16'hFFFF, 1'b1, 16'h0400));
      fetch_q.push_back(mk_instr(CMD_CLD, 8'h00, 16'h0000, 1'b0, 16'h0401));
      fetch_q.push_back(mk_instr(CMD_CLI, 8'h00, 16'h0000, 1'b0, 16'h0402));
      fetch_q.push_back(mk_instr(CMD_CLV, 8'h00, 16'h0000, 1'b0, 16'h0403));
      fetch_q.push_back(mk_instr(CMD_CMP, 8'h00, 16'h0000, 1'b0, 16'h0404));
      fetch_q.push_back(mk_instr(CMD_CPX, 8'hFF, 16'h0000, 1'b0, 16'h0405));
      fetch_q.push_back(mk_instr(CMD_CPY, 8'h00, 16'h0000, 1'b0, 16'h0406));
      fetch_q.push_back(mk_instr(CMD_DEC, 8'h00, 16'h0000, 1'b1, 16'h0407));
      fetch_q.push_back(mk_instr(CMD_DEX, 8'h00, 16'h0000, 1'b0, 16'h0408));
      fetch_q.push_back(mk_instr(CMD_DEY, 8'h00, 16'h0000, 1'b0, 16'h0409));
      fetch_q.push_back(mk_instr(CMD_EOR, 8'hFF, 16'h0000, 1'b0, 16'h040A));
      fetch_q.push_back(mk_instr(CMD_INC, 8'hFF, 16'hFFFF, 1'b0, 16'h040B));
      fetch_q.push_back(mk_instr(CMD_INX, 8'h00, 16'h0000, 1'b0, 16'h040C));
      fetch_q.push_back(mk_instr(CMD_INY, 8'h00, 16'h0000, 1'b0, 16'h040D));
      fetch_q.push_back(mk_instr(CMD_UNUSED_FIRST, 8'h00, 16'h0000, 1'b0, 16'h0000));
      fetch_q.push_back(mk_instr(CMD_UNUSED_LAST, 8'hFF, 16'hFFFF, 1'b1, 16'hFFFF));
      wait_drained();

      write_break_vector(16'h0000);
      repeat (120) fetch_q.push_back(rand_instr(8));
      wait_drained();

      // BRK-heavy stretch: enough pushes to walk SP round the page
      write_break_vector(16'($urandom_range(1, 16'hFFFE)));
      repeat (160) fetch_q.push_back(rand_instr(70));
      wait_drained();

      write_break_vector(16'($urandom_range(0, 65535)));
      repeat (120) fetch_q.push_back(rand_instr(8));
      wait_drained();

      repeat (10) @(posedge clock);
      if (retired_beats.size() != 0)
         log_mismatch("results never arrived", 16'(retired_beats.size()), 16'h0000);

      $display("Ran %0d instructions (%0d BRK) giving %0d result items under stall.",
               instr_count, brk_count, result_count);
      $display("Break vector written %0d times; stack pointer finished at %02h.",
               vector_writes, arch_sp);
      if (mismatch_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
